FILE: rtl/mss_pkg.sv
// Shared widths, register indexes, run mode codes and reset values for the step sequencer.
`default_nettype none
package mss_pkg;

    localparam int LEVEL_W    = 16;
    localparam int COUNT_W    = 5;
    localparam int RAND_W     = 16;
    localparam int STEP_IDX_W = 4;
    localparam int HOLD_W     = 16;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [LEVEL_W-1:0]  level_t;
    typedef logic        [COUNT_W-1:0]  count_t;
    typedef logic        [RAND_W-1:0]   rand_t;
    typedef logic        [STEP_IDX_W-1:0] step_idx_t;
    typedef logic        [HOLD_W-1:0]   hold_t;
    typedef logic        [MODE_W-1:0]   mode_t;
    typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

    localparam mode_t MODE_FORWARD  = 3'd0;
    localparam mode_t MODE_BACKWARD = 3'd1;
    localparam mode_t MODE_PINGPONG = 3'd2;
    localparam mode_t MODE_RWALK    = 3'd3;
    localparam mode_t MODE_RJUMP    = 3'd4;

    localparam cfg_idx_t REG_RUN_MODE   = 2'd0;
    localparam cfg_idx_t REG_TRIG_HIGH  = 2'd1;
    localparam cfg_idx_t REG_TRIG_LOW   = 2'd2;
    localparam cfg_idx_t REG_HOLD_TICKS = 2'd3;

    localparam mode_t  RUN_MODE_RST   = MODE_FORWARD;
    localparam level_t TRIG_HIGH_RST  = 16'sd1000;
    localparam level_t TRIG_LOW_RST   = 16'sd0;
    localparam hold_t  HOLD_TICKS_RST = 16'd48;

endpackage
`default_nettype wire

FILE: rtl/mss_in_if.sv
// Sample tick channel: clock and reset levels, channel count and random word.
`default_nettype none
interface mss_in_if;
    import mss_pkg::*;

    logic   valid;
    logic   ready;
    level_t clk_level;
    level_t rst_level;
    count_t channel_count;
    rand_t  rand_word;

    modport source (output valid, output clk_level, output rst_level,
                    output channel_count, output rand_word, input ready);
    modport sink   (input valid, input clk_level, input rst_level,
                    input channel_count, input rand_word, output ready);
endinterface
`default_nettype wire

FILE: rtl/mss_out_if.sv
// Result channel: selected step and active flag.
`default_nettype none
interface mss_out_if;
    import mss_pkg::*;

    logic      valid;
    logic      ready;
    step_idx_t step_index;
    logic      active;

    modport source (output valid, output step_index, output active, input ready);
    modport sink   (input valid, input step_index, input active, output ready);
endinterface
`default_nettype wire

FILE: rtl/mss_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none
interface mss_cfg_if;
    import mss_pkg::*;

    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/mss_mod.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module mss_mod #(
    parameter int NW = 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW:0]   dividend,
    input  wire logic [NW-1:0] divisor,
    output logic               done,
    output logic [NW-1:0]      rem
);
    import mss_pkg::*;

    localparam int VW = NW + 1;
    localparam int CW = $clog2(VW + 1);

    logic [NW-1:0] rem_reg, rem_next;
    logic [NW:0]   dvd_reg, dvd_next;
    logic [NW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW:0]   trial;
    logic [NW:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[NW]};
        diff      = trial - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CW'(VW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[NW-1:0];
            end
            else
            begin
                rem_next = trial[NW-1:0];
            end
            dvd_next = {dvd_reg[NW-1:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

FILE: rtl/multimode_step_sequencer_unit.sv
// Top level of the multimode step sequencer: triggers, hold counter and step advance.
//
//  channel  dir  payload                                        word accepted when
//  -------  ---  ---------------------------------------------  ------------------
//  sample   in   clk_level, rst_level, channel_count, rand_word  valid && ready
//  result   out  step_index, active                             valid && ready
//  cfg      in   index, data                                    valid && ready
//
// A sample with no clock edge to act on passes the tick state to done; random jump or an
// undefined mode passes the advance state too, one step up or down also waits for one
// remainder from the remainder unit and ping-pong for two; that unit takes one dividend bit per cycle.
// sample.ready is high only while the sequencer is idle; cfg is always ready.
// A finished word waits in the result register while the next sample is taken; a word
// still held there when the next one is done stalls the sequencer until it is taken.
// Reset clears the control state and loads the register defaults; the sample registers are not reset.
`default_nettype none
module multimode_step_sequencer_unit #(
    parameter int MAX_CHANNELS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mss_in_if.sink    sample,
    mss_out_if.source result,
    mss_cfg_if.sink   cfg
);
    import mss_pkg::*;

    localparam int NW    = $clog2(MAX_CHANNELS + 1);
    localparam int SW    = $clog2(MAX_CHANNELS);
    localparam int VW    = NW + 1;
    localparam int CMP_W = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int XW    = (SW > STEP_IDX_W) ? SW : STEP_IDX_W;
    localparam int PW    = RAND_W + NW;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_CHANNELS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_ADV,
        S_WAIT_UP,
        S_WAIT_DN,
        S_DONE
    } state_t;

    state_t    state_reg, state_next;
    mode_t     run_mode_reg;
    level_t    trig_high_reg;
    level_t    trig_low_reg;
    hold_t     hold_ticks_reg;

    logic [SW-1:0] step_reg, step_next;
    logic          going_down_reg, going_down_next;
    logic          clk_hi_reg, clk_hi_next;
    logic          rst_hi_reg, rst_hi_next;
    hold_t         hold_reg, hold_next;

    level_t        clk_lvl_reg;
    level_t        rst_lvl_reg;
    logic [NW-1:0] n_reg;
    rand_t         rnd_reg;
    logic [NW-1:0] up_reg, up_next;

    logic          out_valid_reg, out_valid_next;
    step_idx_t     out_step_reg, out_step_next;
    logic          out_active_reg, out_active_next;

    logic [CMP_W-1:0] count_ext;
    logic [NW-1:0]    n_sat;
    logic             rst_edge;
    logic             clk_edge;
    hold_t            hold_eff;
    logic             blocked;
    logic [PW-1:0]    jump_prod;
    logic [VW-1:0]    up_sum;
    logic [VW-1:0]    dn_sum;
    logic [XW-1:0]    step_x;
    logic [NW-1:0]    step_n;

    logic             mod_start;
    logic             mod_use_dn;
    logic             mod_done;
    logic [NW-1:0]    mod_rem;

    mss_mod #(
        .NW (NW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_use_dn ? dn_sum : up_sum),
        .divisor  (n_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign count_ext = CMP_W'(sample.channel_count);
    assign n_sat     = (count_ext > MAX_C) ? NW'(MAX_C) : NW'(count_ext);
    assign rst_edge  = !rst_hi_reg && (rst_lvl_reg >= trig_high_reg);
    assign clk_edge  = !clk_hi_reg && (clk_lvl_reg >= trig_high_reg);
    assign hold_eff  = rst_edge ? hold_ticks_reg : hold_reg;
    assign blocked   = hold_eff != '0;
    assign jump_prod = {{NW{1'b0}}, rnd_reg} * {{RAND_W{1'b0}}, n_reg};
    assign up_sum    = VW'(step_reg) + VW'(1);
    assign dn_sum    = VW'(step_reg) + VW'(n_reg) - VW'(1);
    assign step_x    = XW'(step_reg);
    assign step_n    = NW'(step_reg);

    assign sample.ready      = (state_reg == S_IDLE);
    assign cfg.ready         = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.step_index = out_step_reg;
    assign result.active     = out_active_reg;

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        going_down_next = going_down_reg;
        clk_hi_next     = clk_hi_reg;
        rst_hi_next     = rst_hi_reg;
        hold_next       = hold_reg;
        up_next         = up_reg;
        out_valid_next  = out_valid_reg;
        out_step_next   = out_step_reg;
        out_active_next = out_active_reg;
        mod_start       = 1'b0;
        mod_use_dn      = 1'b0;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = S_TICK;
                end
            end
            S_TICK:
            begin
                state_next = S_DONE;
                if (n_reg != '0)
                begin
                    rst_hi_next = rst_hi_reg ? !(rst_lvl_reg <= trig_low_reg)
                                             : (rst_lvl_reg >= trig_high_reg);
                    clk_hi_next = clk_hi_reg ? !(clk_lvl_reg <= trig_low_reg)
                                             : (clk_lvl_reg >= trig_high_reg);
                    hold_next   = blocked ? hold_eff - HOLD_W'(1) : hold_eff;
                    if (rst_edge)
                    begin
                        step_next = '0;
                    end
                    if (clk_edge && !blocked)
                    begin
                        state_next = S_ADV;
                    end
                end
            end
            S_ADV:
            begin
                case (run_mode_reg) inside
                    MODE_FORWARD, MODE_PINGPONG:
                    begin
                        mod_start  = 1'b1;
                        state_next = S_WAIT_UP;
                    end
                    MODE_BACKWARD:
                    begin
                        mod_start  = 1'b1;
                        mod_use_dn = 1'b1;
                        state_next = S_WAIT_DN;
                    end
                    MODE_RWALK:
                    begin
                        mod_start  = 1'b1;
                        mod_use_dn = !rnd_reg[0];
                        state_next = rnd_reg[0] ? S_WAIT_UP : S_WAIT_DN;
                    end
                    MODE_RJUMP:
                    begin
                        step_next  = jump_prod[RAND_W +: SW];
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WAIT_UP:
            begin
                if (mod_done)
                begin
                    up_next = mod_rem;
                    if (run_mode_reg == MODE_PINGPONG)
                    begin
                        mod_start  = 1'b1;
                        mod_use_dn = 1'b1;
                        state_next = S_WAIT_DN;
                    end
                    else
                    begin
                        step_next  = SW'(mod_rem);
                        state_next = S_DONE;
                    end
                end
            end
            S_WAIT_DN:
            begin
                if (mod_done)
                begin
                    state_next = S_DONE;
                    if (run_mode_reg == MODE_PINGPONG)
                    begin
                        if (going_down_reg)
                        begin
                            if (mod_rem > step_n)
                            begin
                                step_next       = SW'(up_reg);
                                going_down_next = 1'b0;
                            end
                            else
                            begin
                                step_next = SW'(mod_rem);
                            end
                        end
                        else
                        begin
                            if (up_reg < step_n)
                            begin
                                step_next       = SW'(mod_rem);
                                going_down_next = 1'b1;
                            end
                            else
                            begin
                                step_next = SW'(up_reg);
                            end
                        end
                    end
                    else
                    begin
                        step_next = SW'(mod_rem);
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_active_next = (n_reg != '0);
                    out_step_next   = (n_reg != '0) ? step_x[STEP_IDX_W-1:0] : '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            run_mode_reg   <= RUN_MODE_RST;
            trig_high_reg  <= TRIG_HIGH_RST;
            trig_low_reg   <= TRIG_LOW_RST;
            hold_ticks_reg <= HOLD_TICKS_RST;
            step_reg       <= '0;
            going_down_reg <= 1'b0;
            clk_hi_reg     <= 1'b0;
            rst_hi_reg     <= 1'b0;
            hold_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_step_reg   <= '0;
            out_active_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            going_down_reg <= going_down_next;
            clk_hi_reg     <= clk_hi_next;
            rst_hi_reg     <= rst_hi_next;
            hold_reg       <= hold_next;
            out_valid_reg  <= out_valid_next;
            out_step_reg   <= out_step_next;
            out_active_reg <= out_active_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_RUN_MODE:   run_mode_reg   <= cfg.data[MODE_W-1:0];
                    REG_TRIG_HIGH:  trig_high_reg  <= level_t'(cfg.data);
                    REG_TRIG_LOW:   trig_low_reg   <= level_t'(cfg.data);
                    REG_HOLD_TICKS: hold_ticks_reg <= cfg.data;
                    default:        run_mode_reg   <= run_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            clk_lvl_reg <= sample.clk_level;
            rst_lvl_reg <= sample.rst_level;
            n_reg       <= n_sat;
            rnd_reg     <= sample.rand_word;
        end
        up_reg <= up_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("sample taken while an earlier one is in flight");

    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.active |-> result.step_index == '0)
        else $error("inactive result carries a nonzero step");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> mod_rem < n_reg)
        else $error("remainder not below channel count");

    a_direction_pingpong: assert property (@(posedge clk) disable iff (!rst_n)
        going_down_reg != $past(going_down_reg) |-> $past(run_mode_reg) == MODE_PINGPONG)
        else $error("direction changed outside ping-pong mode");
`endif

endmodule
`default_nettype wire
